>>> src/ffps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffps_pkg
// Types, codes and constants shared by the program/erase sequencer.
// ----------------------------------------------------------------------------
package ffps_pkg;

    localparam int unsigned ADDR_W      = 24;
    localparam int unsigned MAX_RESULTS = 3;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned TIMER_W     = 14;

    // flash command bytes
    localparam logic [7:0] FL_PROGRAM     = 8'h40;
    localparam logic [7:0] FL_ERASE_SETUP = 8'h20;
    localparam logic [7:0] FL_ERASE_CONF  = 8'hD0;
    localparam logic [7:0] FL_READ_ARRAY  = 8'hFF;
    localparam logic [7:0] FL_READ_ID     = 8'h90;

    // status register bits
    localparam int unsigned ST_READY_BIT    = 7;
    localparam int unsigned ST_VPP_ERR_BIT  = 4;
    localparam int unsigned ST_PROG_ERR_BIT = 3;

    localparam logic [16:0] VPP_HIGH_MARGIN = 17'd500;
    localparam logic [23:0] VPP_LOW_NUM     = 24'd95;
    localparam logic [23:0] VPP_LOW_DEN     = 24'd100;

    localparam logic [TIMER_W-1:0] TIMER_MAX = {TIMER_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_PROGRAM    = 3'd0,
        CMD_CHIP_ERASE = 3'd1,
        CMD_CHECKID    = 3'd2,
        CMD_READRET    = 3'd3,
        CMD_TICK       = 3'd4,
        CMD_CLEANUP    = 3'd5,
        CMD_VPP        = 3'd6
    } t_cmd;

    typedef enum logic [2:0] {
        CFG_TARGET_VPP = 3'd0,
        CFG_EXP_ID     = 3'd1,
        CFG_FORCE      = 3'd2,
        CFG_PROG_TMO   = 3'd3,
        CFG_ERASE_TMO  = 3'd4
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REPORT = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        RESP_OK   = 2'd0,
        RESP_WARN = 2'd1,
        RESP_ERR  = 2'd2
    } t_resp;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_VPP_FAULT = 3'd1,
        ERR_PROG      = 3'd2,
        ERR_TIMEOUT   = 3'd3,
        ERR_ID        = 3'd4,
        ERR_VPP_HIGH  = 3'd5,
        ERR_VPP_LOW   = 3'd6
    } t_err;

    typedef enum logic [4:0] {
        PH_IDLE       = 5'b00001,
        PH_POLL_PROG  = 5'b00010,
        PH_POLL_ERASE = 5'b00100,
        PH_ID_HIGH    = 5'b01000,
        PH_ID_LOW     = 5'b10000
    } t_phase;

    typedef struct packed {
        logic [2:0]        command;
        logic [ADDR_W-1:0] target_address;
        logic [7:0]        write_byte;
        logic              last_in_block;
        logic [7:0]        read_byte;
        logic [15:0]       measured_vpp_mv;
    } t_in_item;

    typedef struct packed {
        logic [1:0]        action;
        logic [ADDR_W-1:0] bus_address;
        logic [7:0]        bus_data;
        logic [1:0]        response;
        logic [2:0]        error_kind;
        logic              op_done;
    } t_result;

    // all results caused by one input transaction
    typedef struct packed {
        logic [1:0]                   count;
        logic                         vpp_enable;
        t_result [MAX_RESULTS-1:0]    res;
    } t_burst;

    function automatic t_result mk_res(t_action act, logic [ADDR_W-1:0] addr,
                                       logic [7:0] data, t_resp resp, t_err kind,
                                       logic done);
        t_result r;
        r.action      = act;
        r.bus_address = addr;
        r.bus_data    = data;
        r.response    = resp;
        r.error_kind  = kind;
        r.op_done     = done;
        return r;
    endfunction

endpackage
`default_nettype wire

>>> src/ffps_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffps_in_if
// Input event channel: command, program data, read returns, supply samples.
// ----------------------------------------------------------------------------
interface ffps_in_if
    import ffps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [2:0]        command;
    logic [ADDR_W-1:0] target_address;
    logic [7:0]        write_byte;
    logic              last_in_block;
    logic [7:0]        read_byte;
    logic [15:0]       measured_vpp_mv;

    modport source (
        output valid, command, target_address, write_byte, last_in_block,
               read_byte, measured_vpp_mv,
        input  ready
    );
    modport sink (
        input  valid, command, target_address, write_byte, last_in_block,
               read_byte, measured_vpp_mv,
        output ready
    );
endinterface
`default_nettype wire

>>> src/ffps_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffps_out_if
// Result channel: bus accesses and status reports.
// ----------------------------------------------------------------------------
interface ffps_out_if
    import ffps_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [1:0]        action;
    logic [ADDR_W-1:0] bus_address;
    logic [7:0]        bus_data;
    logic              vpp_enable;
    logic [1:0]        response;
    logic [2:0]        error_kind;
    logic              op_done;
    logic              last;

    modport source (
        output valid, action, bus_address, bus_data, vpp_enable, response,
               error_kind, op_done, last,
        input  ready
    );
    modport sink (
        input  valid, action, bus_address, bus_data, vpp_enable, response,
               error_kind, op_done, last,
        output ready
    );
endinterface
`default_nettype wire

>>> src/ffps_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffps_core
// Sequencer state, configuration registers and per-event decision logic.
// ----------------------------------------------------------------------------
module ffps_core
    import ffps_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 24
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_accept,
    input  wire t_in_item              i_item,
    output logic                       o_push,
    output t_burst                     o_burst
);

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BITS >= ADDR_W) ?
        {ADDR_W{1'b1}} : ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);

    logic [15:0]        r_target_vpp;
    logic [15:0]        r_exp_id;
    logic               r_force;
    logic [TIMER_W-1:0] r_prog_tmo;
    logic [TIMER_W-1:0] r_erase_tmo;

    t_phase             r_phase,     n_phase;
    logic [TIMER_W-1:0] r_timer,     n_timer;
    logic [7:0]         r_id_high,   n_id_high;
    logic               r_vpp_on,    n_vpp_on;
    logic               r_failed,    n_failed;
    logic               r_blk_end,   n_blk_end;

    t_burst             w_burst;
    logic [TIMER_W-1:0] w_timer_inc;
    logic [TIMER_W-1:0] w_limit;
    logic [15:0]        w_id;
    logic               w_id_bad;
    logic               w_vpp_high;
    logic               w_vpp_low;
    logic [23:0]        w_low_lhs;
    logic [23:0]        w_low_rhs;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_polling;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_vpp <= 16'd12000;
            r_exp_id     <= 16'd0;
            r_force      <= 1'b0;
            r_prog_tmo   <= TIMER_W'(150);
            r_erase_tmo  <= TIMER_W'(15000);
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_TARGET_VPP: r_target_vpp <= i_cfg_data;
                CFG_EXP_ID:     r_exp_id     <= i_cfg_data;
                CFG_FORCE:      r_force      <= i_cfg_data[0];
                CFG_PROG_TMO:   r_prog_tmo   <= i_cfg_data[TIMER_W-1:0];
                CFG_ERASE_TMO:  r_erase_tmo  <= i_cfg_data[TIMER_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_addr      = i_item.target_address & ADDR_MASK;
    assign w_polling   = (r_phase == PH_POLL_PROG) || (r_phase == PH_POLL_ERASE);
    assign w_timer_inc = (r_timer != TIMER_MAX) ? r_timer + TIMER_W'(1) : r_timer;
    assign w_limit     = (r_phase == PH_POLL_PROG) ? r_prog_tmo : r_erase_tmo;
    assign w_id        = {r_id_high, i_item.read_byte};
    assign w_id_bad    = (r_exp_id != 16'd0) && (w_id != r_exp_id);
    assign w_vpp_high  = {1'b0, i_item.measured_vpp_mv} > ({1'b0, r_target_vpp} + VPP_HIGH_MARGIN);
    // mv < floor(95*t/100)  <=>  100*(mv+1) <= 95*t
    assign w_low_lhs   = (24'(i_item.measured_vpp_mv) + 24'd1) * VPP_LOW_DEN;
    assign w_low_rhs   = 24'(r_target_vpp) * VPP_LOW_NUM;
    assign w_vpp_low   = w_low_lhs <= w_low_rhs;

    always_comb begin
        n_phase   = r_phase;
        n_timer   = r_timer;
        n_id_high = r_id_high;
        n_vpp_on  = r_vpp_on;
        n_failed  = r_failed;
        n_blk_end = r_blk_end;
        w_burst   = '0;

        unique case (i_item.command)
            CMD_PROGRAM: begin
                if (r_phase == PH_IDLE) begin
                    if (r_failed) begin
                        w_burst.count  = 2'd1;
                        w_burst.res[0] = mk_res(ACT_REPORT, '0, 8'h00, RESP_ERR,
                                                ERR_NONE, 1'b1);
                    end else begin
                        w_burst.count  = 2'd3;
                        w_burst.res[0] = mk_res(ACT_WRITE, w_addr, FL_PROGRAM, RESP_OK,
                                                ERR_NONE, 1'b0);
                        w_burst.res[1] = mk_res(ACT_WRITE, w_addr, i_item.write_byte,
                                                RESP_OK, ERR_NONE, 1'b0);
                        w_burst.res[2] = mk_res(ACT_READ, '0, 8'h00, RESP_OK,
                                                ERR_NONE, 1'b0);
                        n_phase   = PH_POLL_PROG;
                        n_timer   = '0;
                        n_blk_end = i_item.last_in_block;
                    end
                end
            end
            CMD_CHIP_ERASE: begin
                if (r_phase == PH_IDLE) begin
                    n_vpp_on       = 1'b1;
                    w_burst.count  = 2'd3;
                    w_burst.res[0] = mk_res(ACT_WRITE, '0, FL_ERASE_SETUP, RESP_OK,
                                            ERR_NONE, 1'b0);
                    w_burst.res[1] = mk_res(ACT_WRITE, '0, FL_ERASE_CONF, RESP_OK,
                                            ERR_NONE, 1'b0);
                    w_burst.res[2] = mk_res(ACT_READ, '0, 8'h00, RESP_OK, ERR_NONE, 1'b0);
                    n_phase = PH_POLL_ERASE;
                    n_timer = '0;
                end
            end
            CMD_CHECKID: begin
                if (r_phase == PH_IDLE) begin
                    w_burst.count  = 2'd2;
                    w_burst.res[0] = mk_res(ACT_WRITE, '0, FL_READ_ID, RESP_OK,
                                            ERR_NONE, 1'b0);
                    w_burst.res[1] = mk_res(ACT_READ, '0, 8'h00, RESP_OK, ERR_NONE, 1'b0);
                    n_phase = PH_ID_HIGH;
                end
            end
            CMD_READRET: begin
                if (r_phase == PH_ID_HIGH) begin
                    n_id_high      = i_item.read_byte;
                    w_burst.count  = 2'd1;
                    w_burst.res[0] = mk_res(ACT_READ, ADDR_W'(1) & ADDR_MASK, 8'h00,
                                            RESP_OK, ERR_NONE, 1'b0);
                    n_phase = PH_ID_LOW;
                end else if (r_phase == PH_ID_LOW) begin
                    w_burst.count  = 2'd1;
                    w_burst.res[0] = mk_res(ACT_WRITE, '0, FL_READ_ARRAY, RESP_OK,
                                            ERR_NONE, 1'b1);
                    if (w_id_bad) begin
                        w_burst.res[0].error_kind = ERR_ID;
                        if (r_force) begin
                            w_burst.res[0].response = RESP_WARN;
                        end else begin
                            w_burst.res[0].response = RESP_ERR;
                            n_failed = 1'b1;
                            n_vpp_on = 1'b0;
                        end
                    end
                    n_phase = PH_IDLE;
                end else if (w_polling) begin
                    w_burst.count = 2'd1;
                    priority if (!i_item.read_byte[ST_READY_BIT]) begin
                        w_burst.res[0] = mk_res(ACT_READ, '0, 8'h00, RESP_OK,
                                                ERR_NONE, 1'b0);
                    end else if (i_item.read_byte[ST_VPP_ERR_BIT] ||
                                 i_item.read_byte[ST_PROG_ERR_BIT]) begin
                        w_burst.res[0] = mk_res(ACT_WRITE, '0, FL_READ_ARRAY, RESP_ERR,
                            i_item.read_byte[ST_VPP_ERR_BIT] ? ERR_VPP_FAULT : ERR_PROG,
                            1'b1);
                        n_failed  = 1'b1;
                        n_phase   = PH_IDLE;
                        n_timer   = '0;
                        n_blk_end = 1'b0;
                    end else begin
                        w_burst.res[0] = mk_res(ACT_REPORT, '0, 8'h00, RESP_OK, ERR_NONE,
                            (r_phase == PH_POLL_PROG) ? r_blk_end : 1'b1);
                        n_phase   = PH_IDLE;
                        n_timer   = '0;
                        n_blk_end = 1'b0;
                    end
                end
            end
            CMD_TICK: begin
                if (w_polling) begin
                    n_timer = w_timer_inc;
                    if (w_timer_inc >= w_limit) begin
                        w_burst.count  = 2'd1;
                        w_burst.res[0] = mk_res(ACT_WRITE, '0, FL_READ_ARRAY, RESP_ERR,
                                                ERR_TIMEOUT, 1'b1);
                        n_failed  = 1'b1;
                        n_phase   = PH_IDLE;
                        n_timer   = '0;
                        n_blk_end = 1'b0;
                    end
                end
            end
            CMD_CLEANUP: begin
                w_burst.count  = 2'd1;
                w_burst.res[0] = mk_res(ACT_WRITE, '0, FL_READ_ARRAY, RESP_OK,
                                        ERR_NONE, 1'b1);
                n_vpp_on  = 1'b0;
                n_failed  = 1'b0;
                n_phase   = PH_IDLE;
                n_timer   = '0;
                n_blk_end = 1'b0;
            end
            CMD_VPP: begin
                w_burst.count  = 2'd1;
                w_burst.res[0] = mk_res(ACT_REPORT, '0, 8'h00, RESP_OK, ERR_NONE, 1'b1);
                if (w_vpp_high) begin
                    w_burst.res[0].error_kind = ERR_VPP_HIGH;
                    if (r_force) begin
                        w_burst.res[0].response = RESP_WARN;
                    end else begin
                        w_burst.res[0].response = RESP_ERR;
                        n_failed = 1'b1;
                        n_vpp_on = 1'b0;
                    end
                end else if (w_vpp_low) begin
                    w_burst.res[0].error_kind = ERR_VPP_LOW;
                    w_burst.res[0].response   = RESP_WARN;
                end
            end
            default: ;
        endcase

        w_burst.vpp_enable = n_vpp_on;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_timer   <= '0;
            r_id_high <= '0;
            r_vpp_on  <= 1'b0;
            r_failed  <= 1'b0;
            r_blk_end <= 1'b0;
        end else if (i_accept) begin
            r_phase   <= n_phase;
            r_timer   <= n_timer;
            r_id_high <= n_id_high;
            r_vpp_on  <= n_vpp_on;
            r_failed  <= n_failed;
            r_blk_end <= n_blk_end;
        end
    end

    assign o_push  = i_accept && (w_burst.count != 2'd0);
    assign o_burst = w_burst;

endmodule
`default_nettype wire

>>> src/ffps_rq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ffps_rq
// Two-entry result queue; each entry holds every result of one transaction
// and is drained one result per output transaction.
// ----------------------------------------------------------------------------
module ffps_rq
    import ffps_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_burst i_burst,
    output logic        o_full,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_result     o_res,
    output logic        o_vpp_enable,
    output logic        o_last
);

    t_burst     r_mem [2];
    logic       r_wptr;
    logic       r_rptr;
    logic [1:0] r_count;
    logic [1:0] r_sub;

    t_burst     w_head;
    logic       w_pop;
    logic       w_head_done;

    assign w_head      = r_mem[r_rptr];
    assign o_valid     = r_count != 2'd0;
    assign o_full      = r_count == 2'd2;
    assign w_pop       = o_valid && i_ready;
    assign w_head_done = r_sub == (w_head.count - 2'd1);

    assign o_res        = w_head.res[r_sub];
    assign o_vpp_enable = w_head.vpp_enable;
    assign o_last       = w_head_done;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_burst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
            r_sub   <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (w_pop) begin
                if (w_head_done) begin
                    r_sub  <= 2'd0;
                    r_rptr <= ~r_rptr;
                end else begin
                    r_sub <= r_sub + 2'd1;
                end
            end
            r_count <= r_count + {1'b0, i_push} - {1'b0, w_pop && w_head_done};
        end
    end

endmodule
`default_nettype wire

>>> src/flash_program_erase_sequencer.sv
`default_nettype none
// ----------------------------------------------------------------------------
// flash_program_erase_sequencer
// Program/erase/ID sequencer for a command-set flash device.
// ----------------------------------------------------------------------------
// Usage:
//   i_in carries events: program byte, erase, check id, read return, ms tick,
//   cleanup and supply sample. o_out carries the bus writes, bus reads and
//   status reports that an event causes (zero to three of them, the final
//   one flagged with last). Configuration registers must be written through
//   i_cfg_wr_en / i_cfg_idx / i_cfg_data only while the block is idle; the
//   block does not enforce this. Decision logic is one pass and its results
//   are registered in the result queue, so the first result of an event
//   reaches o_out once the result groups ahead of it have drained. An event
//   can be taken every cycle while the queue is not full; the output channel
//   moves one result per cycle while o_out.ready is high. A two-entry queue
//   of result groups sits between the sides, and i_in.ready drops only when
//   both entries are waiting. Events that cause no result are not queued.
//   Reset (synchronous, active low) returns to idle, VPP off, no failure,
//   empty queue and the default configuration. A stalled receiver holds the
//   current result steady and backs up into i_in.ready.
// ----------------------------------------------------------------------------
module flash_program_erase_sequencer
    import ffps_pkg::*;
#(
    parameter int unsigned ADDR_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    ffps_in_if.sink                     i_in,
    ffps_out_if.source                  o_out
);

    t_in_item w_item;
    t_burst   w_burst;
    t_result  w_res;
    logic     w_push;
    logic     w_full;
    logic     w_accept;

    assign w_item.command         = i_in.command;
    assign w_item.target_address  = i_in.target_address;
    assign w_item.write_byte      = i_in.write_byte;
    assign w_item.last_in_block   = i_in.last_in_block;
    assign w_item.read_byte       = i_in.read_byte;
    assign w_item.measured_vpp_mv = i_in.measured_vpp_mv;

    assign i_in.ready = !w_full;
    assign w_accept   = i_in.valid && !w_full;

    ffps_core #(
        .ADDR_BITS (ADDR_BITS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (w_accept),
        .i_item      (w_item),
        .o_push      (w_push),
        .o_burst     (w_burst)
    );

    ffps_rq u_rq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_burst      (w_burst),
        .o_full       (w_full),
        .o_valid      (o_out.valid),
        .i_ready      (o_out.ready),
        .o_res        (w_res),
        .o_vpp_enable (o_out.vpp_enable),
        .o_last       (o_out.last)
    );

    assign o_out.action      = w_res.action;
    assign o_out.bus_address = w_res.bus_address;
    assign o_out.bus_data    = w_res.bus_data;
    assign o_out.response    = w_res.response;
    assign o_out.error_kind  = w_res.error_kind;
    assign o_out.op_done     = w_res.op_done;

endmodule
`default_nettype wire

>>> test/ffps_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ffps_checker
// Watches the event and result channels of the program/erase sequencer,
// predicts the bus operations each accepted event causes and compares every
// accepted result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module ffps_checker
    import ffps_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_item,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [1:0]            i_out_action,
    input  logic [ADDR_W-1:0]     i_out_bus_address,
    input  logic [7:0]            i_out_bus_data,
    input  logic                  i_out_vpp_enable,
    input  logic [1:0]            i_out_response,
    input  logic [2:0]            i_out_error_kind,
    input  logic                  i_out_op_done,
    input  logic                  i_out_last,
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam logic [15:0]        RST_TARGET_MV = 16'd12000;
    localparam logic [15:0]        RST_CHIP_ID   = 16'd0;
    localparam logic [TIMER_W-1:0] RST_PROG_TMO  = 14'd150;
    localparam logic [TIMER_W-1:0] RST_ERASE_TMO = 14'd15000;
    localparam int unsigned        HIGH_MARGIN   = 500;
    localparam int unsigned        LOW_PCT       = 95;

    typedef struct {
        t_action           action;
        logic [ADDR_W-1:0] bus_address;
        logic [7:0]        bus_data;
        logic              vpp_enable;
        t_resp             response;
        t_err              error_kind;
        logic              op_done;
        logic              last;
    } t_bus_op;

    t_bus_op bus_op_q[$];
    int      mismatches;

    // shadow configuration
    logic [15:0]        target_mv;
    logic [15:0]        chip_id;
    logic               force_ovr;
    logic [TIMER_W-1:0] prog_tmo;
    logic [TIMER_W-1:0] erase_tmo;

    // shadow sequencer state
    t_phase             phase;
    logic [TIMER_W-1:0] poll_timer;
    logic [7:0]         id_hi;
    logic               vpp_on;
    logic               failed;
    logic               blk_end;

    assign o_fail_count = mismatches;

    function automatic t_bus_op bus_op(t_action act, logic [ADDR_W-1:0] addr,
                                       logic [7:0] data, t_resp resp, t_err kind,
                                       logic done);
        t_bus_op op;
        op.action      = act;
        op.bus_address = addr;
        op.bus_data    = data;
        op.vpp_enable  = 1'b0;
        op.response    = resp;
        op.error_kind  = kind;
        op.op_done     = done;
        op.last        = 1'b0;
        return op;
    endfunction

    task automatic predict_bus_ops(input t_in_item ev);
        t_bus_op     burst[$];
        t_err        fail_kind;
        t_resp       resp;
        t_err        kind;
        logic [15:0] id;
        logic [TIMER_W-1:0] lim;
        int unsigned tgt;
        int unsigned mv;
        fail_kind = ERR_NONE;
        case (ev.command)
            CMD_PROGRAM: begin
                if (phase == PH_IDLE) begin
                    if (failed) begin
                        burst.push_back(bus_op(ACT_REPORT, '0, 8'h00, RESP_ERR, ERR_NONE, 1'b1));
                    end else begin
                        burst.push_back(bus_op(ACT_WRITE, ev.target_address, FL_PROGRAM,
                                               RESP_OK, ERR_NONE, 1'b0));
                        burst.push_back(bus_op(ACT_WRITE, ev.target_address, ev.write_byte,
                                               RESP_OK, ERR_NONE, 1'b0));
                        burst.push_back(bus_op(ACT_READ, '0, 8'h00, RESP_OK, ERR_NONE, 1'b0));
                        phase      = PH_POLL_PROG;
                        poll_timer = '0;
                        blk_end    = ev.last_in_block;
                    end
                end
            end
            CMD_CHIP_ERASE: begin
                if (phase == PH_IDLE) begin
                    vpp_on = 1'b1;
                    burst.push_back(bus_op(ACT_WRITE, '0, FL_ERASE_SETUP, RESP_OK, ERR_NONE, 1'b0));
                    burst.push_back(bus_op(ACT_WRITE, '0, FL_ERASE_CONF, RESP_OK, ERR_NONE, 1'b0));
                    burst.push_back(bus_op(ACT_READ, '0, 8'h00, RESP_OK, ERR_NONE, 1'b0));
                    phase      = PH_POLL_ERASE;
                    poll_timer = '0;
                end
            end
            CMD_CHECKID: begin
                if (phase == PH_IDLE) begin
                    burst.push_back(bus_op(ACT_WRITE, '0, FL_READ_ID, RESP_OK, ERR_NONE, 1'b0));
                    burst.push_back(bus_op(ACT_READ, '0, 8'h00, RESP_OK, ERR_NONE, 1'b0));
                    phase = PH_ID_HIGH;
                end
            end
            CMD_READRET: begin
                case (phase)
                    PH_ID_HIGH: begin
                        id_hi = ev.read_byte;
                        burst.push_back(bus_op(ACT_READ, 24'd1, 8'h00, RESP_OK, ERR_NONE, 1'b0));
                        phase = PH_ID_LOW;
                    end
                    PH_ID_LOW: begin
                        id   = {id_hi, ev.read_byte};
                        resp = RESP_OK;
                        kind = ERR_NONE;
                        if (chip_id != 16'd0 && id != chip_id) begin
                            kind = ERR_ID;
                            if (force_ovr) begin
                                resp = RESP_WARN;
                            end else begin
                                resp   = RESP_ERR;
                                failed = 1'b1;
                                vpp_on = 1'b0;
                            end
                        end
                        burst.push_back(bus_op(ACT_WRITE, '0, FL_READ_ARRAY, resp, kind, 1'b1));
                        phase = PH_IDLE;
                    end
                    PH_POLL_PROG, PH_POLL_ERASE: begin
                        if (!ev.read_byte[ST_READY_BIT]) begin
                            burst.push_back(bus_op(ACT_READ, '0, 8'h00, RESP_OK, ERR_NONE, 1'b0));
                        end else if (ev.read_byte[ST_VPP_ERR_BIT]) begin
                            fail_kind = ERR_VPP_FAULT;
                        end else if (ev.read_byte[ST_PROG_ERR_BIT]) begin
                            fail_kind = ERR_PROG;
                        end else begin
                            burst.push_back(bus_op(ACT_REPORT, '0, 8'h00, RESP_OK, ERR_NONE,
                                                   (phase == PH_POLL_PROG) ? blk_end : 1'b1));
                            phase      = PH_IDLE;
                            poll_timer = '0;
                            blk_end    = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            CMD_TICK: begin
                if (phase == PH_POLL_PROG || phase == PH_POLL_ERASE) begin
                    lim = (phase == PH_POLL_PROG) ? prog_tmo : erase_tmo;
                    if (poll_timer != TIMER_MAX)
                        poll_timer = poll_timer + TIMER_W'(1);
                    if (poll_timer >= lim)
                        fail_kind = ERR_TIMEOUT;
                end
            end
            CMD_CLEANUP: begin
                burst.push_back(bus_op(ACT_WRITE, '0, FL_READ_ARRAY, RESP_OK, ERR_NONE, 1'b1));
                vpp_on     = 1'b0;
                failed     = 1'b0;
                phase      = PH_IDLE;
                poll_timer = '0;
                blk_end    = 1'b0;
            end
            CMD_VPP: begin
                tgt  = 32'(target_mv);
                mv   = 32'(ev.measured_vpp_mv);
                resp = RESP_OK;
                kind = ERR_NONE;
                if (mv > tgt + HIGH_MARGIN) begin
                    kind = ERR_VPP_HIGH;
                    if (force_ovr) begin
                        resp = RESP_WARN;
                    end else begin
                        resp   = RESP_ERR;
                        failed = 1'b1;
                        vpp_on = 1'b0;
                    end
                end else if (mv < tgt * LOW_PCT / 100) begin
                    kind = ERR_VPP_LOW;
                    resp = RESP_WARN;
                end
                burst.push_back(bus_op(ACT_REPORT, '0, 8'h00, resp, kind, 1'b1));
            end
            default: ;
        endcase

        // status error or poll timeout: back to read-array mode, block programming
        if (fail_kind != ERR_NONE) begin
            burst.push_back(bus_op(ACT_WRITE, '0, FL_READ_ARRAY, RESP_ERR, fail_kind, 1'b1));
            failed     = 1'b1;
            phase      = PH_IDLE;
            poll_timer = '0;
            blk_end    = 1'b0;
        end

        foreach (burst[k]) begin
            burst[k].vpp_enable = vpp_on;
            burst[k].last       = (k == burst.size() - 1);
            bus_op_q.push_back(burst[k]);
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_bus_op want;
        if (!i_rst_n) begin
            bus_op_q.delete();
            mismatches = 0;
            target_mv  = RST_TARGET_MV;
            chip_id    = RST_CHIP_ID;
            force_ovr  = 1'b0;
            prog_tmo   = RST_PROG_TMO;
            erase_tmo  = RST_ERASE_TMO;
            phase      = PH_IDLE;
            poll_timer = '0;
            id_hi      = '0;
            vpp_on     = 1'b0;
            failed     = 1'b0;
            blk_end    = 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_TARGET_VPP: target_mv = i_cfg_data;
                    CFG_EXP_ID:     chip_id   = i_cfg_data;
                    CFG_FORCE:      force_ovr = i_cfg_data[0];
                    CFG_PROG_TMO:   prog_tmo  = i_cfg_data[TIMER_W-1:0];
                    CFG_ERASE_TMO:  erase_tmo = i_cfg_data[TIMER_W-1:0];
                    default: ;
                endcase
            end
            // results are registered, so check before predicting
            if (i_out_valid && i_out_ready) begin
                if (bus_op_q.size() == 0) begin
                    $error("unexpected result: action %0h address %0h data %0h",
                           i_out_action, i_out_bus_address, i_out_bus_data);
                    mismatches++;
                end else begin
                    want = bus_op_q.pop_front();
                    check_field("action", 32'(want.action), 32'(i_out_action));
                    check_field("bus_address", 32'(want.bus_address), 32'(i_out_bus_address));
                    check_field("bus_data", 32'(want.bus_data), 32'(i_out_bus_data));
                    check_field("vpp_enable", 32'(want.vpp_enable), 32'(i_out_vpp_enable));
                    check_field("response", 32'(want.response), 32'(i_out_response));
                    check_field("error_kind", 32'(want.error_kind), 32'(i_out_error_kind));
                    check_field("op_done", 32'(want.op_done), 32'(i_out_op_done));
                    check_field("last", 32'(want.last), 32'(i_out_last));
                end
            end
            if (i_in_valid && i_in_ready)
                predict_bus_ops(i_in_item);
        end
        o_pending <= bus_op_q.size();
    end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the program/erase sequencer: directed sequences for each
// operation and error path, then randomized well-formed and broken operation
// sequences under several configurations, with random stalls on both channels in all but one randomized pass.
// ----------------------------------------------------------------------------
module tb_top;
    import ffps_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 4;
    localparam int ITEMS_PER_PASS = 17;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    logic                  gaps_on;
    logic                  in_took;
    int                    fail_count;
    int                    pending;
    int                    n_items;
    int                    stall_cycles = 0;

    logic [15:0]           cur_target;
    logic [15:0]           cur_chip_id;
    int                    cur_prog_tmo;
    int                    cur_erase_tmo;

    ffps_in_if  in_ch ();
    ffps_out_if out_ch ();

    flash_program_erase_sequencer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    ffps_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (cfg_wr_en),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_data        (cfg_data),
        .i_in_valid        (in_ch.valid),
        .i_in_ready        (in_ch.ready),
        .i_in_item         ({in_ch.command, in_ch.target_address, in_ch.write_byte,
                             in_ch.last_in_block, in_ch.read_byte, in_ch.measured_vpp_mv}),
        .i_out_valid       (out_ch.valid),
        .i_out_ready       (out_ch.ready),
        .i_out_action      (out_ch.action),
        .i_out_bus_address (out_ch.bus_address),
        .i_out_bus_data    (out_ch.bus_data),
        .i_out_vpp_enable  (out_ch.vpp_enable),
        .i_out_response    (out_ch.response),
        .i_out_error_kind  (out_ch.error_kind),
        .i_out_op_done     (out_ch.op_done),
        .i_out_last        (out_ch.last),
        .o_fail_count      (fail_count),
        .o_pending         (pending)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    always @(posedge i_clk) begin
        in_took <= in_ch.valid && in_ch.ready;
    end

    always @(negedge i_clk) begin
        out_ch.ready <= gaps_on ? ($urandom_range(0, 99) >= 16) : 1'b1;
    end

    // no transaction on either channel for too long means a hang
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic t_in_item rand_event(logic [2:0] cmd);
        t_in_item ev;
        ev.command         = cmd;
        ev.target_address  = 24'($urandom);
        ev.write_byte      = 8'($urandom);
        ev.last_in_block   = 1'($urandom);
        ev.read_byte       = 8'($urandom);
        ev.measured_vpp_mv = 16'($urandom);
        return ev;
    endfunction

    // entered and left at a falling edge; valid stays up into the next call
    task automatic send_event(input t_in_item ev);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 16) begin
                in_ch.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        in_ch.valid           <= 1'b1;
        in_ch.command         <= ev.command;
        in_ch.target_address  <= ev.target_address;
        in_ch.write_byte      <= ev.write_byte;
        in_ch.last_in_block   <= ev.last_in_block;
        in_ch.read_byte       <= ev.read_byte;
        in_ch.measured_vpp_mv <= ev.measured_vpp_mv;
        do @(negedge i_clk); while (!in_took);
        n_items++;
    endtask

    task automatic do_cmd(input logic [2:0] cmd);
        send_event(rand_event(cmd));
    endtask

    task automatic do_program(input logic [ADDR_W-1:0] addr, input logic [7:0] data,
                              input logic lib);
        t_in_item ev;
        ev                = rand_event(CMD_PROGRAM);
        ev.target_address = addr;
        ev.write_byte     = data;
        ev.last_in_block  = lib;
        send_event(ev);
    endtask

    task automatic do_read(input logic [7:0] rb);
        t_in_item ev;
        ev           = rand_event(CMD_READRET);
        ev.read_byte = rb;
        send_event(ev);
    endtask

    task automatic do_vpp(input logic [15:0] mv);
        t_in_item ev;
        ev                 = rand_event(CMD_VPP);
        ev.measured_vpp_mv = mv;
        send_event(ev);
    endtask

    // drain all outstanding results, then let event-only work settle
    task automatic wait_quiet();
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_idx   <= idx;
        cfg_data  <= val;
        @(negedge i_clk);
    endtask

    task automatic set_config(input logic [15:0] tgt, input logic [15:0] id, input logic frc,
                              input logic [13:0] ptmo, input logic [13:0] etmo);
        wait_quiet();
        put_reg(CFG_TARGET_VPP, tgt);
        put_reg(CFG_EXP_ID, id);
        put_reg(CFG_FORCE, {15'd0, frc});
        put_reg(CFG_PROG_TMO, {2'd0, ptmo});
        put_reg(CFG_ERASE_TMO, {2'd0, etmo});
        cfg_wr_en     <= 1'b0;
        cur_target    = tgt;
        cur_chip_id   = id;
        cur_prog_tmo  = int'(ptmo);
        cur_erase_tmo = int'(etmo);
    endtask

    // status polling after program or erase: some busy polls and ticks, then
    // ready, an error status, a timeout, or an abandoned poll
    task automatic poll_seq(input int lim);
        int steps;
        int sel;
        steps = $urandom_range(0, 3);
        repeat (steps) begin
            if ($urandom_range(0, 1))
                do_cmd(CMD_TICK);
            else
                do_read(8'($urandom) & 8'h7F);
        end
        sel = $urandom_range(0, 99);
        if (sel < 15 && lim <= 8) begin
            repeat (lim) do_cmd(CMD_TICK);
        end else if (sel < 25) begin
            if ($urandom_range(0, 1))
                do_cmd(CMD_CLEANUP);
        end else if (sel < 70) begin
            do_read(8'h80 | (8'($urandom) & 8'h67));
        end else begin
            do_read(8'h80 | 8'($urandom));
        end
    endtask

    initial begin : stimulus
        int          stop_at;
        int          sel;
        int          hi_mv;
        int          lo_mv;
        int          mv;
        logic [15:0] id;
        logic [15:0] tgt;

        i_rst_n               = 1'b0;
        cfg_wr_en             = 1'b0;
        cfg_idx               = '0;
        cfg_data              = '0;
        in_ch.valid           = 1'b0;
        in_ch.command         = '0;
        in_ch.target_address  = '0;
        in_ch.write_byte      = '0;
        in_ch.last_in_block   = 1'b0;
        in_ch.read_byte       = '0;
        in_ch.measured_vpp_mv = '0;
        gaps_on               = 1'b1;
        n_items               = 0;
        cur_target            = 16'd12000;
        cur_chip_id           = 16'd0;
        cur_prog_tmo          = 150;
        cur_erase_tmo         = 15000;

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // supply checks around the default target, high fault blocks programming
        do_vpp(16'd11400);
        do_vpp(16'd11399);
        do_vpp(16'd12500);
        do_vpp(16'd12501);
        do_program(24'hFFFFFF, 8'hFF, 1'b1);
        do_cmd(CMD_CLEANUP);

        // program with a busy poll, stray events while polling and while idle
        do_program(24'hFFFFFF, 8'hFF, 1'b1);
        do_program(24'h000000, 8'h00, 1'b0);
        do_read(8'h7F);
        do_read(8'h80);
        do_read(8'hFF);
        do_cmd(CMD_TICK);
        do_cmd(3'd7);

        // erase with VPP fault, program with program fault
        do_cmd(CMD_CHIP_ERASE);
        do_read(8'h90);
        do_cmd(CMD_CLEANUP);
        do_program(24'h000000, 8'h00, 1'b0);
        do_read(8'h88);
        do_cmd(CMD_CLEANUP);

        // id read with the compare disabled
        do_cmd(CMD_CHECKID);
        do_read(8'hAB);
        do_read(8'hCD);

        set_config(16'd0, 16'h1234, 1'b0, 14'd1, 14'd2);
        do_cmd(CMD_CHECKID);
        do_read(8'h12);
        do_read(8'h35);
        do_cmd(CMD_CLEANUP);
        do_program(24'h5A5A5A, 8'hA5, 1'b1);
        do_cmd(CMD_TICK);
        do_cmd(CMD_CHIP_ERASE);
        do_cmd(CMD_TICK);
        do_cmd(CMD_TICK);
        do_cmd(CMD_CHIP_ERASE);
        do_read(8'h80);
        do_vpp(16'd501);

        set_config(16'hFFFF, 16'hFFFF, 1'b1, 14'd16383, 14'd16383);
        do_vpp(16'hFFFF);
        do_vpp(16'd0);
        do_cmd(CMD_CHECKID);
        do_read(8'h00);
        do_read(8'h00);

        for (int pass = 0; pass < 4; pass++) begin
            gaps_on = (pass != 2);
            case ($urandom_range(0, 3))
                0:       tgt = 16'd0;
                1:       tgt = 16'hFFFF;
                default: tgt = 16'($urandom_range(3000, 20000));
            endcase
            set_config(tgt,
                       ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom),
                       1'($urandom),
                       ($urandom_range(0, 7) == 0) ? 14'd16383 : 14'($urandom_range(1, 6)),
                       ($urandom_range(0, 7) == 0) ? 14'd16383 : 14'($urandom_range(1, 6)));
            stop_at = n_items + ITEMS_PER_PASS;
            while (n_items < stop_at) begin
                sel = $urandom_range(0, 99);
                if (sel < 30) begin
                    do_program(24'($urandom), 8'($urandom), 1'($urandom));
                    poll_seq(cur_prog_tmo);
                end else if (sel < 45) begin
                    do_cmd(CMD_CHIP_ERASE);
                    poll_seq(cur_erase_tmo);
                end else if (sel < 60) begin
                    do_cmd(CMD_CHECKID);
                    id = $urandom_range(0, 1) ? cur_chip_id : 16'($urandom);
                    do_read(id[15:8]);
                    if ($urandom_range(0, 9) != 0)
                        do_read(id[7:0]);
                end else if (sel < 72) begin
                    hi_mv = int'(cur_target) + 500;
                    lo_mv = int'(cur_target) * 95 / 100;
                    case ($urandom_range(0, 4))
                        0:       mv = hi_mv;
                        1:       mv = hi_mv + 1;
                        2:       mv = lo_mv;
                        3:       mv = (lo_mv > 0) ? lo_mv - 1 : 0;
                        default: mv = $urandom_range(0, 65535);
                    endcase
                    if (mv > 65535)
                        mv = 65535;
                    do_vpp(16'(mv));
                end else if (sel < 80) begin
                    do_cmd(CMD_CLEANUP);
                end else begin
                    repeat ($urandom_range(1, 3)) do_cmd(3'($urandom));
                end
            end
        end

        wait_quiet();
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
